@@ src/pst_pkg.sv @@
package pst_pkg;

  localparam logic [1:0] REQ_TX    = 2'd0;
  localparam logic [1:0] REQ_RX    = 2'd1;
  localparam logic [1:0] REQ_REEST = 2'd2;

  localparam logic [1:0] REG_SN_LEN  = 2'd0;
  localparam logic [1:0] REG_CONTROL = 2'd1;
  localparam logic [1:0] REG_UNACK   = 2'd2;

  localparam logic [3:0] LEN_5  = 4'd5;
  localparam logic [3:0] LEN_7  = 4'd7;
  localparam logic [3:0] LEN_12 = 4'd12;

  localparam logic signed [13:0] REORDER_WINDOW = 14'sd2048;

  localparam logic [7:0] HDR_DATA_BIT = 8'h80;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  hdr_byte_first;
    logic [7:0]  hdr_byte_second;
    logic [12:0] pdu_length;
  } in_word_t;

  typedef struct packed {
    logic [3:0] sn_length_bits;
    logic       control_bearer;
    logic       unack_mode;
    logic       len_written;
  } cfg_t;

  function automatic logic [3:0] eff_len(input logic [3:0] v);
    case (v)
      LEN_5:   eff_len = LEN_5;
      LEN_7:   eff_len = LEN_7;
      default: eff_len = LEN_12;
    endcase
  endfunction

  function automatic logic [11:0] len_mask(input logic [3:0] l);
    case (l)
      LEN_5:   len_mask = 12'h01F;
      LEN_7:   len_mask = 12'h07F;
      default: len_mask = 12'hFFF;
    endcase
  endfunction

  function automatic logic [31:0] make_count(input logic [31:0] hfn, input logic [11:0] sn,
                                             input logic [3:0] l);
    case (l)
      LEN_5:   make_count = {hfn[26:0], 5'b0} | {20'b0, sn};
      LEN_7:   make_count = {hfn[24:0], 7'b0} | {20'b0, sn};
      default: make_count = {hfn[19:0], 12'b0} | {20'b0, sn};
    endcase
  endfunction

endpackage

@@ src/pst_chan_if.sv @@
interface pst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  hdr_byte_first;
  logic [7:0]  hdr_byte_second;
  logic [12:0] pdu_length;

  modport source (output valid, req_type, hdr_byte_first, hdr_byte_second, pdu_length,
                  input ready);
  modport sink (input valid, req_type, hdr_byte_first, hdr_byte_second, pdu_length,
                output ready);
endinterface

interface pst_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_hdr_first;
  logic [7:0]  out_hdr_second;
  logic [1:0]  hdr_length;
  logic [11:0] seq_number;
  logic [31:0] count_value;
  logic        dropped;
  logic [31:0] tx_total;
  logic [31:0] rx_total;

  modport source (output valid, out_hdr_first, out_hdr_second, hdr_length, seq_number,
                  count_value, dropped, tx_total, rx_total, input ready);
  modport sink (input valid, out_hdr_first, out_hdr_second, hdr_length, seq_number,
                count_value, dropped, tx_total, rx_total, output ready);
endinterface

interface pst_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/pst_cfg_regs.sv @@
module pst_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  pst_cfg_if.sink       cfg,
  output pst_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sn_length_bits <= pst_pkg::LEN_12;
      regs.control_bearer <= 1'b0;
      regs.unack_mode     <= 1'b0;
      regs.len_written    <= 1'b0;
    end else begin
      regs.len_written <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          pst_pkg::REG_SN_LEN: begin
            regs.sn_length_bits <= cfg.data;
            regs.len_written    <= 1'b1;
          end
          pst_pkg::REG_CONTROL: regs.control_bearer <= cfg.data[0];
          pst_pkg::REG_UNACK:   regs.unack_mode <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/pst_in_stage.sv @@
module pst_in_stage (
  input  logic              clk,
  input  logic              rst,
  pst_req_if.sink           req,
  input  logic              fire,
  output pst_pkg::in_word_t q,
  output logic              q_valid
);

  assign req.ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q.req_type        <= req.req_type;
      q.hdr_byte_first  <= req.hdr_byte_first;
      q.hdr_byte_second <= req.hdr_byte_second;
      q.pdu_length      <= req.pdu_length;
    end
  end

endmodule

@@ src/pst_engine.sv @@
module pst_engine (
  input  logic              clk,
  input  logic              rst,
  input  pst_pkg::cfg_t     regs,
  input  pst_pkg::in_word_t q,
  input  logic              q_valid,
  output logic              fire,
  pst_rsp_if.source         rsp
);

  logic [31:0] tx_counter, tx_counter_next;
  logic [31:0] rx_counter, rx_counter_next;
  logic [31:0] rx_hyperframe, rx_hyperframe_next;
  logic [11:0] next_rx_sn, next_rx_sn_next;
  logic [11:0] last_rx_sn, last_rx_sn_next;

  logic [3:0]  len;
  logic [11:0] mask;
  logic        len12;
  logic        ctrl;
  logic [31:0] hfn_inc, hfn_dec;
  logic [11:0] rx_sn, sn_inc;
  logic [1:0]  need;
  logic signed [13:0] d_sl, d_ls, d_ns, d_sn;

  logic [7:0]  h0, h1;
  logic [1:0]  hlen;
  logic [11:0] sn;
  logic [31:0] count;
  logic        drop;

  assign fire    = q_valid && (!rsp.valid || rsp.ready);
  assign len     = pst_pkg::eff_len(regs.sn_length_bits);
  assign mask    = pst_pkg::len_mask(len);
  assign len12   = (len == pst_pkg::LEN_12);
  assign ctrl    = regs.control_bearer;
  assign hfn_inc = rx_hyperframe + 32'd1;
  assign hfn_dec = rx_hyperframe - 32'd1;
  assign need    = (!ctrl && len12) ? 2'd2 : 2'd1;

  always_comb begin
    if (ctrl) begin
      rx_sn = {7'b0, q.hdr_byte_first[4:0]};
    end else if (len12) begin
      rx_sn = {q.hdr_byte_first[3:0], q.hdr_byte_second};
    end else begin
      rx_sn = {4'b0, q.hdr_byte_first} & mask;
    end
  end

  assign sn_inc = rx_sn + 12'd1;
  assign d_sl   = $signed({2'b0, rx_sn}) - $signed({2'b0, last_rx_sn});
  assign d_ls   = $signed({2'b0, last_rx_sn}) - $signed({2'b0, rx_sn});
  assign d_ns   = $signed({2'b0, next_rx_sn}) - $signed({2'b0, rx_sn});
  assign d_sn   = $signed({2'b0, rx_sn}) - $signed({2'b0, next_rx_sn});

  always_comb begin
    tx_counter_next    = tx_counter;
    rx_counter_next    = rx_counter;
    rx_hyperframe_next = rx_hyperframe;
    next_rx_sn_next    = next_rx_sn;
    last_rx_sn_next    = last_rx_sn;
    h0    = 8'd0;
    h1    = 8'd0;
    hlen  = 2'd0;
    sn    = 12'd0;
    count = 32'd0;
    drop  = 1'b0;
    case (q.req_type)
      pst_pkg::REQ_TX: begin
        count = tx_counter;
        if (ctrl) begin
          sn   = {7'b0, tx_counter[4:0]};
          h0   = {3'b0, tx_counter[4:0]};
          hlen = 2'd1;
        end else if (len12) begin
          sn   = tx_counter[11:0];
          h0   = pst_pkg::HDR_DATA_BIT | {4'b0, tx_counter[11:8]};
          h1   = tx_counter[7:0];
          hlen = 2'd2;
        end else begin
          sn   = tx_counter[11:0] & mask;
          h0   = pst_pkg::HDR_DATA_BIT | sn[7:0];
          hlen = 2'd1;
        end
        tx_counter_next = tx_counter + 32'd1;
      end
      pst_pkg::REQ_RX: begin
        if (q.pdu_length <= {11'b0, need}) begin
          drop = 1'b1;
        end else begin
          hlen = need;
          sn   = rx_sn;
          rx_counter_next = rx_counter + 32'd1;
          if (ctrl) begin
            count = {20'b0, rx_sn};
          end else if (regs.unack_mode) begin
            if (rx_sn < next_rx_sn) begin
              count = pst_pkg::make_count(hfn_inc, rx_sn, len);
              if (rx_sn == mask) begin
                next_rx_sn_next    = 12'd0;
                rx_hyperframe_next = rx_hyperframe + 32'd2;
              end else begin
                next_rx_sn_next    = sn_inc;
                rx_hyperframe_next = hfn_inc;
              end
            end else begin
              count = pst_pkg::make_count(rx_hyperframe, rx_sn, len);
              if (rx_sn == mask) begin
                next_rx_sn_next    = 12'd0;
                rx_hyperframe_next = hfn_inc;
              end else begin
                next_rx_sn_next = sn_inc;
              end
            end
          end else begin
            last_rx_sn_next = rx_sn;
            if (d_sl > pst_pkg::REORDER_WINDOW || d_ls > pst_pkg::REORDER_WINDOW) begin
              count = pst_pkg::make_count((rx_sn > next_rx_sn) ? hfn_dec : rx_hyperframe,
                                          rx_sn, len);
            end else if (d_ns > pst_pkg::REORDER_WINDOW) begin
              rx_hyperframe_next = hfn_inc;
              count              = pst_pkg::make_count(hfn_inc, rx_sn, len);
              next_rx_sn_next    = sn_inc;
            end else if (d_sn >= pst_pkg::REORDER_WINDOW) begin
              count = pst_pkg::make_count(hfn_dec, rx_sn, len);
            end else if (rx_sn >= next_rx_sn) begin
              count = pst_pkg::make_count(rx_hyperframe, rx_sn, len);
              if (rx_sn == mask) begin
                next_rx_sn_next    = 12'd0;
                rx_hyperframe_next = hfn_inc;
              end else begin
                next_rx_sn_next = sn_inc;
              end
            end else begin
              count = pst_pkg::make_count(rx_hyperframe, rx_sn, len);
            end
          end
        end
      end
      pst_pkg::REQ_REEST: begin
        if (ctrl || regs.unack_mode) begin
          tx_counter_next    = 32'd0;
          rx_counter_next    = 32'd0;
          rx_hyperframe_next = 32'd0;
          next_rx_sn_next    = 12'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_counter    <= 32'd0;
      rx_counter    <= 32'd0;
      rx_hyperframe <= 32'd0;
      next_rx_sn    <= 12'd0;
      last_rx_sn    <= 12'hFFF;
      rsp.valid     <= 1'b0;
    end else begin
      if (regs.len_written) begin
        last_rx_sn <= mask;
      end else if (fire) begin
        last_rx_sn <= last_rx_sn_next;
      end
      if (fire) begin
        tx_counter    <= tx_counter_next;
        rx_counter    <= rx_counter_next;
        rx_hyperframe <= rx_hyperframe_next;
        next_rx_sn    <= next_rx_sn_next;
        rsp.valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.out_hdr_first  <= h0;
      rsp.out_hdr_second <= h1;
      rsp.hdr_length     <= hlen;
      rsp.seq_number     <= sn;
      rsp.count_value    <= count;
      rsp.dropped        <= drop;
      rsp.tx_total       <= tx_counter_next;
      rsp.rx_total       <= rx_counter_next;
    end
  end

`ifndef SYNTHESIS
  a_fire_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.valid)
    else $error("accepted request produced no result word");

  a_drop_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.dropped) |->
      (rsp.hdr_length == 2'd0 && rsp.seq_number == 12'd0 && rsp.count_value == 32'd0))
    else $error("dropped word carries header or count");

  a_tx_counts_up: assert property (@(posedge clk) disable iff (rst)
    (fire && q.req_type == pst_pkg::REQ_TX) |=> (rsp.tx_total == $past(tx_counter) + 32'd1))
    else $error("transmit counter did not advance by one");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (fire && drop) |=> ($stable(rx_hyperframe) && $stable(next_rx_sn) && $stable(rx_counter)))
    else $error("dropped pdu changed receive state");
`endif

endmodule

@@ src/pdcp_sn_count_tracker_unit.sv @@
// datapath: an accepted request word is held in the input register, then its
//   result word is registered in the output register
// throughput: one request word per cycle while the result side is ready; a
//   stalled result word holds at most one more request in the input register
// reset: synchronous rst clears counters, hyperframe and next sn, sets the
//   last received sn to all ones and the sn length to 12
module pdcp_sn_count_tracker_unit (
  input  logic     clk,
  input  logic     rst,
  pst_cfg_if.sink  cfg,
  pst_req_if.sink  req,
  pst_rsp_if.source rsp
);

  pst_pkg::cfg_t     regs;
  pst_pkg::in_word_t q;
  logic              q_valid;
  logic              fire;

  pst_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pst_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .fire    (fire),
    .q       (q),
    .q_valid (q_valid)
  );

  pst_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q       (q),
    .q_valid (q_valid),
    .fire    (fire),
    .rsp     (rsp)
  );

endmodule
